// ----- src/hashed_set_assoc_edge_cache_defines.svh -----
// Assertion macros used by the transition cache checker.
`ifndef HASHED_SET_ASSOC_EDGE_CACHE_DEFINES_SVH
`define HASHED_SET_ASSOC_EDGE_CACHE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define HSAC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define HSAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/hsac_pkg.sv -----
// Types and constants of the transition cache.
package hsac_pkg;

	// Field widths of one item.
	localparam int STATE_W  = 10;
	localparam int CP_W     = 21;
	localparam int CTX_W    = 6;
	localparam int MODE_W   = 2;

	// Stream widths.
	localparam int IN_TDATA_W  = 48;
	localparam int IN_TUSER_W  = MODE_W;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_TUSER_W = 1;

	// Hash multipliers and fold distance.
	localparam logic [31:0] MUL_STATE  = 32'h9e37_79b1;
	localparam logic [31:0] MUL_CP     = 32'h85eb_ca6b;
	localparam logic [31:0] MUL_CTX    = 32'hc2b2_ae35;
	localparam int          FOLD_SHIFT = 16;

	// Operation codes carried in the input tuser.
	typedef enum logic [MODE_W-1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_FLUSH  = 2'd2
	} mode_t;

	// One way of a set: the key and the stored next state.
	typedef struct packed {
		logic [STATE_W-1:0] target;
		logic [CTX_W-1:0]   context_bits;
		logic [CP_W-1:0]    symbol;
		logic [STATE_W-1:0] source;
	} way_t;

endpackage

// ----- src/hashed_set_assoc_edge_cache.sv -----
// Transition cache of a regex scanner: hashed set-associative store in one memory.
//
// Each item is a lookup, an insert or a flush selected by s_tuser, and each gives
// exactly one result item. The hash products are registered as the item is
// accepted, the set row is read from the single-port row memory in the next
// cycle, and the cycle after that resolves hit or victim and, on an insert,
// writes the row back; s_tready rises again only once the item has resolved
// into a free output register. A flush, and likewise the release of reset, runs
// a clearing pass that writes one set row per cycle over all NUM_SETS rows
// (1024 by default); no item is accepted during that pass. The result of a
// flush leaves at once. A lookup that misses, and every insert, flush or unused
// operation, returns hit 0 and target 0.
module hashed_set_assoc_edge_cache
	import hsac_pkg::*;
#(
	parameter int NUM_SETS = 1024,
	parameter int NUM_WAYS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// state_id [9:0], code_point [30:10], context_req [36:31], new_target [46:37]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// mode [1:0]
	input  logic [IN_TUSER_W-1:0]  s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// target_state [9:0]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// hit [0]
	output logic [OUT_TUSER_W-1:0] m_tuser
);

	localparam int AW = $clog2(NUM_SETS);
	localparam int PW = $clog2(NUM_WAYS);
	localparam logic [AW-1:0] SET_MASK = AW'(NUM_SETS - 1);
	localparam logic [AW-1:0] LAST_SET = AW'(NUM_SETS - 1);
	localparam logic [PW:0]   WAY_COUNT = (PW + 1)'(NUM_WAYS);
	localparam logic [PW-1:0] LAST_WAY = PW'(NUM_WAYS - 1);

	// One memory row holds a whole set.
	typedef struct packed {
		logic [PW-1:0]       ptr;
		logic [NUM_WAYS-1:0] valid;
		way_t [NUM_WAYS-1:0] ways;
	} row_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_IDX,
		ST_RES,
		ST_CLR
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_q;
	logic                 out_valid_q;
	logic                 hit_q;
	logic [STATE_W-1:0]   target_q;

	mode_t                mode_q;
	way_t                 key_q;
	logic [31:0]          prod_state_q;
	logic [31:0]          prod_cp_q;
	logic [31:0]          prod_ctx_q;
	logic [AW-1:0]        set_q;

	row_t                 mem [NUM_SETS];
	row_t                 rd_data_q;

	logic                 accept;
	logic                 out_free;
	logic [31:0]          prod_state;
	logic [31:0]          prod_cp;
	logic [31:0]          prod_ctx;
	logic [31:0]          hash_mix;
	logic [31:0]          hash_fold;
	logic [AW-1:0]        set_idx;
	way_t                 in_key;

	logic                 hit_any;
	logic [STATE_W-1:0]   hit_target;
	logic                 free_any;
	logic [PW-1:0]        free_way;
	logic [PW-1:0]        victim;
	logic [PW-1:0]        pick;
	logic [PW-1:0]        next_ptr;
	row_t                 upd_row;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	row_t                 mem_wdata;
	logic                 mem_re;

	// Handshake.
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_TDATA_W - STATE_W)'(0), target_q};
	assign m_tuser  = hit_q;

	// Unpack the item fields.
	assign in_key.source       = s_tdata[STATE_W-1:0];
	assign in_key.symbol       = s_tdata[STATE_W+CP_W-1:STATE_W];
	assign in_key.context_bits = s_tdata[STATE_W+CP_W+CTX_W-1:STATE_W+CP_W];
	assign in_key.target       = s_tdata[2*STATE_W+CP_W+CTX_W-1:STATE_W+CP_W+CTX_W];

	// Hash products, one constant multiply per key part, truncated to 32 bits.
	assign prod_state = {(32 - STATE_W)'(0), in_key.source} * MUL_STATE;
	assign prod_cp    = {(32 - CP_W)'(0), in_key.symbol} * MUL_CP;
	assign prod_ctx   = {(32 - CTX_W)'(0), in_key.context_bits} * MUL_CTX;

	// Fold the registered products into a set number.
	assign hash_mix  = prod_state_q ^ prod_cp_q ^ prod_ctx_q;
	assign hash_fold = hash_mix ^ (hash_mix >> FOLD_SHIFT);
	assign set_idx   = hash_fold[AW-1:0] & SET_MASK;

	// Capture the item and its products as it is accepted; keep the set number.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q       <= mode_t'(s_tuser[MODE_W-1:0]);
			key_q        <= in_key;
			prod_state_q <= prod_state;
			prod_cp_q    <= prod_cp;
			prod_ctx_q   <= prod_ctx;
		end
		if (state_q == ST_IDX) begin
			set_q <= set_idx;
		end
	end

	// Resolve the row that was read: lowest matching way, lowest free way, victim.
	always_comb begin
		hit_any    = 1'b0;
		hit_target = '0;
		free_any   = 1'b0;
		free_way   = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (rd_data_q.valid[w] &&
			    rd_data_q.ways[w].source == key_q.source &&
			    rd_data_q.ways[w].symbol == key_q.symbol &&
			    rd_data_q.ways[w].context_bits == key_q.context_bits) begin
				hit_any    = 1'b1;
				hit_target = rd_data_q.ways[w].target;
			end
			if (!rd_data_q.valid[w]) begin
				free_any = 1'b1;
				free_way = PW'(w);
			end
		end
		victim   = ({1'b0, rd_data_q.ptr} >= WAY_COUNT) ? '0 : rd_data_q.ptr;
		pick     = free_any ? free_way : victim;
		next_ptr = free_any ? rd_data_q.ptr :
			((victim == LAST_WAY) ? '0 : victim + 1'b1);
		upd_row             = rd_data_q;
		upd_row.valid[pick] = 1'b1;
		upd_row.ways[pick]  = key_q;
		upd_row.ptr         = next_ptr;
	end

	// Memory port control: row write on insert, zero rows during the clearing pass.
	assign mem_re    = (state_q == ST_IDX);
	assign mem_we    = (state_q == ST_CLR) ||
		((state_q == ST_RES) && out_free && (mode_q == MODE_INSERT));
	assign mem_waddr = (state_q == ST_CLR) ? clr_q : set_q;
	assign mem_wdata = (state_q == ST_CLR) ? row_t'(0) : upd_row;

	// Set row memory, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[set_idx];
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			target_q    <= '0;
		end else begin
			// The result register fills when an item resolves and empties when taken.
			if ((state_q == ST_RES) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_IDX;
					end
				end
				ST_IDX: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (out_free) begin
						hit_q    <= (mode_q == MODE_LOOKUP) && hit_any;
						target_q <= (mode_q == MODE_LOOKUP) ? hit_target : '0;
						if (mode_q == MODE_FLUSH) begin
							clr_q   <= '0;
							state_q <= ST_CLR;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SET) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/hsac_checker.sv -----
// Port-level checker for the transition cache, bound to the top level.
`include "hashed_set_assoc_edge_cache_defines.svh"

module hsac_checker
	import hsac_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,
	input logic [IN_TUSER_W-1:0]  s_tuser,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [OUT_TUSER_W-1:0] m_tuser
);

	// A stalled result keeps its payload.
	`HSAC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// A miss or a non-lookup result always reports target zero.
	`HSAC_ASSERT_SAME(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "miss with nonzero target")

	// Items are taken one at a time, so ready drops right after an accept.
	`HSAC_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item accepted back to back")

endmodule

bind hashed_set_assoc_edge_cache hsac_checker u_hsac_checker (.*);
